FILE: rtl/led_string_pulse_frame_encoder_assert.svh
// Assertion macros shared by the LED string frame encoder RTL.
// Needs no other file; included by the modules that carry assertions.
`ifndef LED_STRING_PULSE_FRAME_ENCODER_ASSERT_SVH
`define LED_STRING_PULSE_FRAME_ENCODER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LSPFE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lspfe: invariant violated");

// When the antecedent holds, the consequent must hold in the same cycle.
`define LSPFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lspfe: same-cycle implication violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define LSPFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lspfe: next-cycle implication violated");

`endif

FILE: rtl/lspfe_pkg.sv
// Types and constants of the LED string frame encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package lspfe_pkg;

    localparam int FRAME_BITS = 26;
    localparam int SEGMENTS   = 54;
    localparam int SEG_W      = $clog2(SEGMENTS);

    // Index of the closing low segment of a frame.
    localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(SEGMENTS - 1);

    typedef logic [FRAME_BITS-1:0] t_frame;

    // Command operation codes.
    localparam logic OP_SET_COLOR = 1'b0;
    localparam logic OP_ENUMERATE = 1'b1;

    // Enumerate direction codes.
    localparam logic [1:0] DIR_CONFIGURED = 2'd0;
    localparam logic [1:0] DIR_FORWARD    = 2'd1;
    localparam logic [1:0] DIR_REVERSE    = 2'd2;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_PHYSICAL_COUNT    = 3'd0,
        REG_LOGICAL_COUNT     = 3'd1,
        REG_DEFAULT_FORWARD   = 3'd2,
        REG_INTENSITY_CAP     = 3'd3,
        REG_BROADCAST_ADDRESS = 3'd4,
        REG_SHORT_TIME        = 3'd5,
        REG_LONG_TIME         = 3'd6,
        REG_END_TIME          = 3'd7
    } t_reg_idx;

    // Reset values of the registers.
    localparam logic [5:0] RST_PHYSICAL_COUNT    = 6'd0;
    localparam logic [5:0] RST_LOGICAL_COUNT     = 6'd0;
    localparam logic       RST_DEFAULT_FORWARD   = 1'b1;
    localparam logic [7:0] RST_INTENSITY_CAP     = 8'd204;
    localparam logic [5:0] RST_BROADCAST_ADDRESS = 6'd63;
    localparam logic [7:0] RST_SHORT_TIME        = 8'd7;
    localparam logic [7:0] RST_LONG_TIME         = 8'd17;
    localparam logic [7:0] RST_END_TIME          = 8'd40;

    typedef struct packed {
        logic [5:0] physical_count;
        logic [5:0] logical_count;
        logic       default_forward;
        logic [7:0] intensity_cap;
        logic [5:0] broadcast_address;
        logic [7:0] short_time;
        logic [7:0] long_time;
        logic [7:0] end_time;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/lspfe_cmd_if.sv
// Command channel of the LED string frame encoder: valid/ready and one command item.
// No dependencies.
`default_nettype none

interface lspfe_cmd_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [5:0]  bulb;
    logic [7:0]  intensity;
    logic [11:0] color;
    logic [1:0]  direction;

    modport source (
        output valid, operation, bulb, intensity, color, direction,
        input  ready
    );
    modport sink (
        input  valid, operation, bulb, intensity, color, direction,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/lspfe_seg_if.sv
// Segment channel of the LED string frame encoder: valid/ready and one pin segment.
// No dependencies.
`default_nettype none

interface lspfe_seg_if;
    logic       valid;
    logic       ready;
    logic       level;
    logic [7:0] duration_us;
    logic       last;

    modport source (
        output valid, level, duration_us, last,
        input  ready
    );
    modport sink (
        input  valid, level, duration_us, last,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/lspfe_front.sv
// Front end: accepts commands, resolves address and intensity, keeps the address offset.
// Depends on lspfe_pkg and lspfe_cmd_if; pushes frame words into lspfe_queue.
`default_nettype none

module lspfe_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    lspfe_cmd_if.sink            s_cmd,
    input  lspfe_pkg::t_cfg      i_cfg,
    input  wire                  i_q_full,
    output logic                 o_push,
    output lspfe_pkg::t_frame    o_frame
);
    import lspfe_pkg::*;

    logic [5:0] r_offset;
    logic [5:0] n_offset;
    logic       accept;
    logic       fwd;
    logic       in_walk;
    logic       walk_end;
    logic [5:0] set_addr;
    logic [7:0] set_inten;
    logic [5:0] enum_addr;

    assign s_cmd.ready = !i_q_full;
    assign accept      = s_cmd.valid && s_cmd.ready;

    always_comb begin
        unique case (s_cmd.direction)
            DIR_FORWARD: fwd = 1'b1;
            DIR_REVERSE: fwd = 1'b0;
            default:     fwd = i_cfg.default_forward;
        endcase
    end

    assign in_walk   = s_cmd.bulb < i_cfg.physical_count;
    assign walk_end  = in_walk && (s_cmd.bulb == 6'(i_cfg.physical_count - 6'd1));
    assign enum_addr = fwd ? s_cmd.bulb
                           : 6'(i_cfg.physical_count - 6'd1 - s_cmd.bulb);

    // The broadcast address goes out unchanged; all others are shifted by the offset.
    assign set_addr  = (s_cmd.bulb == i_cfg.broadcast_address)
                     ? s_cmd.bulb : 6'(s_cmd.bulb + r_offset);
    assign set_inten = (s_cmd.intensity > i_cfg.intensity_cap)
                     ? i_cfg.intensity_cap : s_cmd.intensity;

    always_comb begin
        n_offset = r_offset;
        o_push   = 1'b0;
        o_frame  = {set_addr, set_inten, s_cmd.color};
        if (accept) begin
            if (s_cmd.operation == OP_SET_COLOR) begin
                o_push = 1'b1;
            end else begin
                o_frame = {enum_addr, i_cfg.intensity_cap, 12'd0};
                o_push  = in_walk;
                if (s_cmd.bulb == 6'd0) begin
                    n_offset = 6'd0;
                end
                // At the end of a forward walk the spare bulbs at the start are skipped.
                if (walk_end && fwd && (i_cfg.physical_count > i_cfg.logical_count)) begin
                    n_offset = 6'(i_cfg.physical_count - i_cfg.logical_count);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 6'd0;
        end else begin
            r_offset <= n_offset;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lspfe_queue.sv
// Two-entry frame queue between the front end and the segment sequencer.
// Depends on lspfe_pkg and the assertion macro header.
`default_nettype none
`include "led_string_pulse_frame_encoder_assert.svh"

module lspfe_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  lspfe_pkg::t_frame    i_frame,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire                  i_pop,
    output lspfe_pkg::t_frame    o_frame
);
    import lspfe_pkg::*;

    t_frame     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_frame = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= 2'(r_count + {1'b0, i_push} - {1'b0, i_pop});
        end
    end

    `LSPFE_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= 2'd2)
    `LSPFE_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `LSPFE_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid)
    `LSPFE_ASSERT_ALWAYS(a_ptr_gap, i_clk, i_rst_n, (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))

endmodule

`default_nettype wire

FILE: rtl/lspfe_back.sv
// Back end: turns queued frame words into 54 timed pin segments through an output register.
// Depends on lspfe_pkg, lspfe_seg_if and the assertion macro header.
`default_nettype none
`include "led_string_pulse_frame_encoder_assert.svh"

module lspfe_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lspfe_pkg::t_cfg      i_cfg,
    input  wire                  i_q_valid,
    input  lspfe_pkg::t_frame    i_q_frame,
    output logic                 o_q_pop,
    lspfe_seg_if.source          m_seg
);
    import lspfe_pkg::*;

    logic             r_busy;
    logic [SEG_W-1:0] r_seg;
    t_frame           r_word;
    logic             r_valid;
    logic             r_level;
    logic [7:0]       r_dur;
    logic             r_last;

    logic             n_busy;
    logic [SEG_W-1:0] n_seg;
    t_frame           n_word;
    logic             n_level;
    logic [7:0]       n_dur;
    logic             n_last;

    logic             adv;
    logic [7:0]       dur_short;
    logic [7:0]       dur_long;
    logic [7:0]       dur_end;
    logic             bit_one;

    // A zero timing register is sent as one microsecond.
    assign dur_short = (i_cfg.short_time == 8'd0) ? 8'd1 : i_cfg.short_time;
    assign dur_long  = (i_cfg.long_time  == 8'd0) ? 8'd1 : i_cfg.long_time;
    assign dur_end   = (i_cfg.end_time   == 8'd0) ? 8'd1 : i_cfg.end_time;

    assign adv     = !r_valid || m_seg.ready;
    assign bit_one = r_word[FRAME_BITS-1];
    assign o_q_pop = adv && !r_busy && i_q_valid;

    always_comb begin
        n_busy  = r_busy;
        n_seg   = r_seg;
        n_word  = r_word;
        n_level = r_level;
        n_dur   = r_dur;
        n_last  = r_last;
        if (adv) begin
            if (r_busy) begin
                n_seg  = SEG_W'(r_seg + 1'b1);
                n_last = 1'b0;
                if (r_seg == LAST_SEG) begin
                    n_level = 1'b0;
                    n_dur   = dur_end;
                    n_last  = 1'b1;
                    n_busy  = 1'b0;
                end else if (r_seg[0]) begin
                    // Low half of a bit: long for a one, short for a zero.
                    n_level = 1'b0;
                    n_dur   = bit_one ? dur_long : dur_short;
                end else begin
                    // High half of a bit, after which the next bit moves up.
                    n_level = 1'b1;
                    n_dur   = bit_one ? dur_short : dur_long;
                    n_word  = {r_word[FRAME_BITS-2:0], 1'b0};
                end
            end else if (i_q_valid) begin
                // The start segment needs nothing from the word, so it goes out while loading.
                n_word  = i_q_frame;
                n_seg   = SEG_W'(1);
                n_busy  = 1'b1;
                n_level = 1'b1;
                n_dur   = dur_short;
                n_last  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_seg   <= '0;
        end else begin
            r_busy <= n_busy;
            r_seg  <= n_seg;
            if (adv) begin
                r_valid <= r_busy || i_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_level <= n_level;
        r_dur   <= n_dur;
        r_last  <= n_last;
    end

    assign m_seg.valid       = r_valid;
    assign m_seg.level       = r_level;
    assign m_seg.duration_us = r_dur;
    assign m_seg.last        = r_last;

    `LSPFE_ASSERT_IMPLY(a_seg_range, i_clk, i_rst_n, r_busy, (r_seg != '0) && (r_seg <= LAST_SEG))
    `LSPFE_ASSERT_NEXT(a_frame_done, i_clk, i_rst_n, adv && r_busy && (r_seg == LAST_SEG), !r_busy && r_last && r_valid)
    `LSPFE_ASSERT_IMPLY(a_busy_shows, i_clk, i_rst_n, r_busy, r_valid)

endmodule

`default_nettype wire

FILE: rtl/led_string_pulse_frame_encoder.sv
// LED string frame encoder top level: configuration registers, front end, queue, back end.
// Path: an accepted command's frame word is registered in the queue, then its first segment
// in the back end's output register, when the back end is idle.
// Throughput: one segment per cycle from the back end's output register while the receiver
// is ready; an enumerate index outside the walk is accepted but gives no segment.
// Reset (synchronous, active low) loads register defaults, clears the offset and empties the queue.
// Depends on lspfe_pkg, lspfe_cmd_if, lspfe_seg_if, lspfe_front, lspfe_queue and lspfe_back.
`default_nettype none

module led_string_pulse_frame_encoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lspfe_cmd_if.sink   i_cmd,
    lspfe_seg_if.source o_seg,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lspfe_pkg::*;

    // Configuration registers sit at byte address four times their index. The user must write them
    // only while no frame is in flight (the block does not enforce this), so both ends may read them directly.
    logic [5:0] r_physical_count;
    logic [5:0] r_logical_count;
    logic       r_default_forward;
    logic [7:0] r_intensity_cap;
    logic [5:0] r_broadcast_address;
    logic [7:0] r_short_time;
    logic [7:0] r_long_time;
    logic [7:0] r_end_time;

    t_cfg       cfg;
    t_reg_idx   reg_idx;
    logic       wr_en;

    logic       q_push;
    t_frame     q_in_frame;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    t_frame     q_out_frame;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_physical_count    <= RST_PHYSICAL_COUNT;
            r_logical_count     <= RST_LOGICAL_COUNT;
            r_default_forward   <= RST_DEFAULT_FORWARD;
            r_intensity_cap     <= RST_INTENSITY_CAP;
            r_broadcast_address <= RST_BROADCAST_ADDRESS;
            r_short_time        <= RST_SHORT_TIME;
            r_long_time         <= RST_LONG_TIME;
            r_end_time          <= RST_END_TIME;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PHYSICAL_COUNT:    r_physical_count    <= pwdata[5:0];
                REG_LOGICAL_COUNT:     r_logical_count     <= pwdata[5:0];
                REG_DEFAULT_FORWARD:   r_default_forward   <= pwdata[0];
                REG_INTENSITY_CAP:     r_intensity_cap     <= pwdata[7:0];
                REG_BROADCAST_ADDRESS: r_broadcast_address <= pwdata[5:0];
                REG_SHORT_TIME:        r_short_time        <= pwdata[7:0];
                REG_LONG_TIME:         r_long_time         <= pwdata[7:0];
                REG_END_TIME:          r_end_time          <= pwdata[7:0];
            endcase
        end
    end

    // Read-back is zero-extended to the data width.
    always_comb begin
        unique case (reg_idx)
            REG_PHYSICAL_COUNT:    prdata = {26'd0, r_physical_count};
            REG_LOGICAL_COUNT:     prdata = {26'd0, r_logical_count};
            REG_DEFAULT_FORWARD:   prdata = {31'd0, r_default_forward};
            REG_INTENSITY_CAP:     prdata = {24'd0, r_intensity_cap};
            REG_BROADCAST_ADDRESS: prdata = {26'd0, r_broadcast_address};
            REG_SHORT_TIME:        prdata = {24'd0, r_short_time};
            REG_LONG_TIME:         prdata = {24'd0, r_long_time};
            REG_END_TIME:          prdata = {24'd0, r_end_time};
        endcase
    end

    assign cfg.physical_count    = r_physical_count;
    assign cfg.logical_count     = r_logical_count;
    assign cfg.default_forward   = r_default_forward;
    assign cfg.intensity_cap     = r_intensity_cap;
    assign cfg.broadcast_address = r_broadcast_address;
    assign cfg.short_time        = r_short_time;
    assign cfg.long_time         = r_long_time;
    assign cfg.end_time          = r_end_time;

    // The front end resolves each command that gives a frame into a 26-bit word in the cycle it is
    // accepted, so the address offset is always up to date for the next command.
    lspfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_cmd    (i_cmd),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_frame  (q_in_frame)
    );

    // Two frame words of slack let a new command be taken while a frame is still going out.
    lspfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (q_in_frame),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_frame (q_out_frame)
    );

    // The back end sends a start segment, two segments for each bit and a closing low gap.
    lspfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_frame (q_out_frame),
        .o_q_pop   (q_pop),
        .m_seg     (o_seg)
    );

endmodule

`default_nettype wire

FILE: tb/sv/led_string_pulse_frame_encoder_tb.sv
// Self-checking testbench of the LED string frame encoder: directed and random commands,
// each checked segment by segment against a frame predictor kept in this file.
// Depends on lspfe_pkg, lspfe_cmd_if, lspfe_seg_if and led_string_pulse_frame_encoder.

module led_string_pulse_frame_encoder_tb;
    import lspfe_pkg::*;

    localparam int          SETTLE_CYCLES   = 8;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          STALL_LIMIT     = 4000;
    localparam int          RANDOM_FRAMES   = 100;
    localparam int          REPORT_LIMIT    = 10;
    localparam logic [1:0]  DIR_SPARE       = 2'd3;
    localparam logic [11:0] DARK_COLOUR     = 12'h000;

    // One pin segment as the block hands it out.
    typedef struct packed {
        logic       level;
        logic [7:0] duration_us;
        logic       last;
    } t_seg;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lspfe_cmd_if cmd_bus ();
    lspfe_seg_if seg_bus ();

    // The predictor's own copy of the registers and of the bulb offset.
    t_cfg        reg_copy;
    logic [5:0]  bulb_offset;
    t_seg        pending_segments[$];

    int          mismatch_count = 0;
    int          frames_sent    = 0;
    int          quiet_cycles   = 0;
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    bit          hold_off_req   = 1'b0;

    led_string_pulse_frame_encoder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_bus),
        .o_seg   (seg_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    // A timing register of zero still gives a segment of one microsecond.
    function automatic logic [7:0] pulse_len(input logic [7:0] t);
        return (t == 8'd0) ? 8'd1 : t;
    endfunction

    // Queues the 54 segments of one frame: a high start, two segments per bit
    // sent most significant first, then the low closing gap.
    function automatic void queue_frame(input logic [5:0] addr, input logic [7:0] inten,
                                        input logic [11:0] color);
        logic [FRAME_BITS-1:0] word;
        logic [7:0]            s_len;
        logic [7:0]            l_len;
        word  = {addr, inten, color[11:8], color[7:4], color[3:0]};
        s_len = pulse_len(reg_copy.short_time);
        l_len = pulse_len(reg_copy.long_time);
        pending_segments.push_back('{level: 1'b1, duration_us: s_len, last: 1'b0});
        for (int i = FRAME_BITS - 1; i >= 0; i--) begin
            // A one is low long then high short; a zero is the other way round.
            pending_segments.push_back('{level: 1'b0, duration_us: word[i] ? l_len : s_len,
                                         last: 1'b0});
            pending_segments.push_back('{level: 1'b1, duration_us: word[i] ? s_len : l_len,
                                         last: 1'b0});
        end
        pending_segments.push_back('{level: 1'b0, duration_us: pulse_len(reg_copy.end_time),
                                     last: 1'b1});
    endfunction

    // Works out what one accepted command does; returns 1 when it gives a frame.
    function automatic bit predict_command(input logic op, input logic [5:0] bulb,
                                           input logic [7:0] inten, input logic [11:0] color,
                                           input logic [1:0] dir);
        logic [5:0] addr;
        logic [7:0] level;
        logic       fwd;
        if (op == OP_SET_COLOR) begin
            // The broadcast address goes out as it is; any other wraps round 64 bulbs.
            addr  = (bulb == reg_copy.broadcast_address) ? bulb : bulb + bulb_offset;
            level = (inten > reg_copy.intensity_cap) ? reg_copy.intensity_cap : inten;
            queue_frame(addr, level, color);
            return 1'b1;
        end
        case (dir)
            DIR_FORWARD: fwd = 1'b1;
            DIR_REVERSE: fwd = 1'b0;
            default:     fwd = reg_copy.default_forward;
        endcase
        // The first step of a walk forgets the offset, even when it sends nothing.
        if (bulb == 6'd0)
            bulb_offset = '0;
        if (bulb >= reg_copy.physical_count)
            return 1'b0;
        addr = fwd ? bulb : reg_copy.physical_count - 6'd1 - bulb;
        queue_frame(addr, reg_copy.intensity_cap, DARK_COLOUR);
        // Only the last step of a forward walk sets the offset, and only with spare bulbs.
        if (bulb == reg_copy.physical_count - 6'd1 && fwd &&
            reg_copy.physical_count > reg_copy.logical_count)
            bulb_offset = reg_copy.physical_count - reg_copy.logical_count;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Writes one register through the setup and access phases and mirrors it.
    // The bus is then left idle so that writes never overlap.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PHYSICAL_COUNT:    reg_copy.physical_count    = value[5:0];
            REG_LOGICAL_COUNT:     reg_copy.logical_count     = value[5:0];
            REG_DEFAULT_FORWARD:   reg_copy.default_forward   = value[0];
            REG_INTENSITY_CAP:     reg_copy.intensity_cap     = value[7:0];
            REG_BROADCAST_ADDRESS: reg_copy.broadcast_address = value[5:0];
            REG_SHORT_TIME:        reg_copy.short_time        = value[7:0];
            REG_LONG_TIME:         reg_copy.long_time         = value[7:0];
            REG_END_TIME:          reg_copy.end_time          = value[7:0];
            default: ;
        endcase
    endtask

    // Offers one command item and returns at the edge that accepts it. Valid is
    // left high so that a following item with no gap goes straight on.
    task automatic send_cmd(input logic op, input logic [5:0] bulb, input logic [7:0] inten,
                            input logic [11:0] color, input logic [1:0] dir);
        int gap;
        gap = sender_idles ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.operation <= op;
        cmd_bus.bulb      <= bulb;
        cmd_bus.intensity <= inten;
        cmd_bus.color     <= color;
        cmd_bus.direction <= dir;
        do @(posedge clk); while (!cmd_bus.ready);
        if (predict_command(op, bulb, inten, color, dir))
            frames_sent++;
    endtask

    // Stops offering items, waits for every expected segment, then lets the
    // block's pipeline settle, since a step outside the walk leaves no trace.
    task automatic wait_string_idle();
        cmd_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_segments.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return 8'd1;
            1:       return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults: the string is empty, so every enumerate step is outside
    // the walk, while set colour still clamps and honours the broadcast address.
    task automatic test_reset_defaults();
        send_cmd(OP_SET_COLOR, 6'd0,  8'd255, 12'hFFF, DIR_CONFIGURED);
        send_cmd(OP_SET_COLOR, 6'd63, 8'd0,   12'h000, DIR_CONFIGURED);
        send_cmd(OP_SET_COLOR, 6'd42, 8'd204, 12'hA5C, DIR_REVERSE);
        send_cmd(OP_SET_COLOR, 6'd21, 8'd205, 12'h5A3, DIR_SPARE);
        send_cmd(OP_ENUMERATE, 6'd0,  8'd0,   12'h000, DIR_CONFIGURED);
        send_cmd(OP_ENUMERATE, 6'd63, 8'hFF,  12'hFFF, DIR_SPARE);
        wait_string_idle();
    endtask

    // A forward walk over five bulbs with three in use leaves an offset of two;
    // a reverse walk clears it again and does not set it.
    task automatic test_enumerate_walk();
        write_reg(REG_PHYSICAL_COUNT, 32'd5);
        write_reg(REG_LOGICAL_COUNT, 32'd3);
        for (int k = 0; k < 5; k++)
            send_cmd(OP_ENUMERATE, 6'(k), 8'd17, 12'hABC, DIR_CONFIGURED);
        send_cmd(OP_SET_COLOR, 6'd1,  8'd100, 12'h321, DIR_CONFIGURED);
        send_cmd(OP_SET_COLOR, 6'd63, 8'd100, 12'h456, DIR_CONFIGURED);
        send_cmd(OP_SET_COLOR, 6'd62, 8'd100, 12'h789, DIR_CONFIGURED);
        send_cmd(OP_ENUMERATE, 6'd0, 8'd0, 12'h000, DIR_REVERSE);
        send_cmd(OP_ENUMERATE, 6'd4, 8'd0, 12'h000, DIR_REVERSE);
        send_cmd(OP_SET_COLOR, 6'd1, 8'd1, 12'hF0F, DIR_CONFIGURED);
        send_cmd(OP_ENUMERATE, 6'd5, 8'd0, 12'h000, DIR_FORWARD);
        wait_string_idle();
        // With the default direction reversed, the spare code follows it too.
        write_reg(REG_DEFAULT_FORWARD, 32'd0);
        send_cmd(OP_ENUMERATE, 6'd4, 8'd0, 12'h000, DIR_SPARE);
        wait_string_idle();
    endtask

    // Timing registers at their limits, a zero short time among them, and the
    // intensity ceiling at both ends.
    task automatic test_timing_extremes();
        write_reg(REG_SHORT_TIME, 32'd0);
        write_reg(REG_LONG_TIME, 32'd255);
        write_reg(REG_END_TIME, 32'd255);
        write_reg(REG_INTENSITY_CAP, 32'd255);
        write_reg(REG_BROADCAST_ADDRESS, 32'd0);
        send_cmd(OP_SET_COLOR, 6'd0,  8'd255, 12'hFFF, DIR_CONFIGURED);
        send_cmd(OP_SET_COLOR, 6'd63, 8'd128, 12'h000, DIR_CONFIGURED);
        wait_string_idle();
        write_reg(REG_SHORT_TIME, 32'd255);
        write_reg(REG_LONG_TIME, 32'd1);
        write_reg(REG_END_TIME, 32'd1);
        write_reg(REG_INTENSITY_CAP, 32'd0);
        send_cmd(OP_SET_COLOR, 6'd31, 8'd255, 12'h123, DIR_CONFIGURED);
        send_cmd(OP_ENUMERATE, 6'd2,  8'd99,  12'hEEE, DIR_FORWARD);
        wait_string_idle();
    endtask

    // Phases of random settings, each a walk followed by set colour commands and
    // a little noise. The first two phases take the settings to their extremes;
    // the third holds the receiver off while the sender keeps pushing.
    task automatic test_random_traffic();
        int         start_frames;
        int         phase;
        int         n_cmds;
        logic [5:0] phys;
        logic [5:0] logi;
        logic       fwd_bit;
        logic [7:0] ceiling;
        logic [5:0] bcast;
        logic [7:0] t_short;
        logic [7:0] t_long;
        logic [7:0] t_end;
        logic [1:0] walk_dir;
        logic [5:0] bulb;
        start_frames = frames_sent;
        phase        = 0;
        while (frames_sent < start_frames + RANDOM_FRAMES) begin
            wait_string_idle();
            if (phase == 0) begin
                phys = 6'd63; logi = 6'd0; fwd_bit = 1'b1; ceiling = 8'd255; bcast = 6'd63;
                t_short = 8'd255; t_long = 8'd255; t_end = 8'd255;
            end else if (phase == 1) begin
                phys = 6'd1; logi = 6'd63; fwd_bit = 1'b0; ceiling = 8'd0; bcast = 6'd0;
                t_short = 8'd1; t_long = 8'd1; t_end = 8'd1;
            end else begin
                phys    = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(0, 8));
                logi    = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(0, phys));
                fwd_bit = 1'($urandom_range(0, 1));
                ceiling = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
                bcast   = 6'($urandom_range(0, 63));
                t_short = pick_time();
                t_long  = pick_time();
                t_end   = pick_time();
            end
            write_reg(REG_PHYSICAL_COUNT, 32'(phys));
            write_reg(REG_LOGICAL_COUNT, 32'(logi));
            write_reg(REG_DEFAULT_FORWARD, 32'(fwd_bit));
            write_reg(REG_INTENSITY_CAP, 32'(ceiling));
            write_reg(REG_BROADCAST_ADDRESS, 32'(bcast));
            write_reg(REG_SHORT_TIME, 32'(t_short));
            write_reg(REG_LONG_TIME, 32'(t_long));
            write_reg(REG_END_TIME, 32'(t_end));

            // Stretches without idling on one side or the other.
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            if (phase == 2) begin
                hold_off_req = 1'b1;
                sender_idles = 1'b0;
            end

            // The walk; a long string only gets its head and its tail.
            walk_dir = 2'($urandom_range(0, 3));
            for (int k = 0; k < phys; k++) begin
                if (phys <= 12 || k < 4 || k >= phys - 4)
                    send_cmd(OP_ENUMERATE, 6'(k), 8'($urandom), 12'($urandom),
                             ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : walk_dir);
            end

            n_cmds = $urandom_range(3, 8);
            repeat (n_cmds) begin
                bulb = ($urandom_range(0, 3) == 0) ? bcast : 6'($urandom_range(0, 63));
                send_cmd(OP_SET_COLOR, bulb,
                         ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom_range(0, 255)),
                         12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)));
            end

            // In the third phase the sender pauses for the string to empty before the noise.
            if (phase == 2)
                wait_string_idle();
            n_cmds = $urandom_range(0, 2);
            repeat (n_cmds)
                send_cmd(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                         8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                         2'($urandom_range(0, 3)));
            phase++;
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.operation = OP_SET_COLOR;
        cmd_bus.bulb      = '0;
        cmd_bus.intensity = '0;
        cmd_bus.color     = '0;
        cmd_bus.direction = DIR_CONFIGURED;
        reg_copy = '{physical_count:    RST_PHYSICAL_COUNT,
                     logical_count:     RST_LOGICAL_COUNT,
                     default_forward:   RST_DEFAULT_FORWARD,
                     intensity_cap:     RST_INTENSITY_CAP,
                     broadcast_address: RST_BROADCAST_ADDRESS,
                     short_time:        RST_SHORT_TIME,
                     long_time:         RST_LONG_TIME,
                     end_time:          RST_END_TIME};
        bulb_offset = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_enumerate_walk();
        test_timing_extremes();
        test_random_traffic();

        // Every segment has arrived and the pipeline has had time to settle.
        wait_string_idle();
        if (mismatch_count == 0) begin
            $display("led_string_pulse_frame_encoder regression: pass");
        end else begin
            $display("led_string_pulse_frame_encoder regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Segment receiver: a random wait before each item while it idles, and once a long
    // hold-off so that the block backs up and refuses commands.
    // ------------------------------------------------------------------

    initial begin : segment_sink
        int gap;
        seg_bus.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_off_req) begin
                seg_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else begin
                gap = receiver_idles ? $urandom_range(0, 3) : 0;
                if (gap > 0) begin
                    seg_bus.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            seg_bus.ready <= 1'b1;
            do @(posedge clk); while (!seg_bus.valid);
        end
    end

    // ------------------------------------------------------------------
    // Segment checker: each accepted segment against the oldest one expected.
    // ------------------------------------------------------------------

    always @(posedge clk) begin : segment_check
        t_seg seen;
        t_seg want;
        if (rst_n && seg_bus.valid && seg_bus.ready) begin
            seen = '{level: seg_bus.level, duration_us: seg_bus.duration_us,
                     last: seg_bus.last};
            if (pending_segments.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("segment with none expected: level %0b duration %0d last %0b",
                             seen.level, seen.duration_us, seen.last);
            end else begin
                want = pending_segments.pop_front();
                if (seen.level !== want.level || seen.duration_us !== want.duration_us ||
                    seen.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"segment mismatch: expected level %0b duration %0d last %0b,",
                                  " got level %0b duration %0d last %0b"},
                                 want.level, want.duration_us, want.last,
                                 seen.level, seen.duration_us, seen.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves for too long.
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (seg_bus.valid && seg_bus.ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("led_string_pulse_frame_encoder regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
